>>> sv/olink_pkg.sv
// Shared types and constants for the overlay link enumerator.
`default_nettype none
package olink_pkg;

    localparam int PW = 11;   // peer index, offset and row length width
    localparam int CW = 23;   // link counter width (clique of 2047 peers)

    localparam logic [1:0] MODE_LINE   = 2'd0;
    localparam logic [1:0] MODE_RING   = 2'd1;
    localparam logic [1:0] MODE_CLIQUE = 2'd2;
    localparam logic [1:0] MODE_TORUS  = 2'd3;

    localparam logic CFG_PEER_COUNT = 1'b0;
    localparam logic CFG_MODE       = 1'b1;

    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_SIMPLE = 2'd1,
        PH_ROWS   = 2'd2,
        PH_COLS   = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase          phase;
        logic [PW-1:0]   x;
        logic [PW-1:0]   y;
        logic [PW-1:0]   off;
        logic [PW-1:0]   cur;
    } t_walk;

endpackage
`default_nettype wire

>>> sv/olink_row_mem.sv
// Row length store: one write port, one registered read port.
`default_nettype none
module olink_row_mem
    import olink_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [PW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [PW-1:0] o_rdata
);
    logic [PW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/olink_step.sv
// One iteration of the topology walk: emit a link, skip, or stop.
`default_nettype none
module olink_step
    import olink_pkg::*;
(
    input  wire t_walk          i_walk,
    input  wire logic [PW-1:0]  i_len,
    input  wire logic [PW-1:0]  i_len0,
    input  wire logic [PW-1:0]  i_row_total,
    input  wire logic [PW-1:0]  i_n,
    input  wire logic [1:0]     i_mode,
    output t_walk               o_walk,
    output logic                o_emit,
    output logic                o_stop,
    output logic [PW-1:0]       o_a,
    output logic [PW-1:0]       o_b
);
    logic [PW:0] x1, y1;
    logic [PW-1:0] ox;

    assign x1 = {1'b0, i_walk.x} + 1'b1;
    assign y1 = {1'b0, i_walk.y} + 1'b1;
    assign ox = i_walk.off + i_walk.x;

    always_comb begin
        o_walk = i_walk;
        o_emit = 1'b0;
        o_stop = 1'b0;
        o_a    = '0;
        o_b    = '0;
        case (i_walk.phase)
            PH_DONE: begin
                o_stop = 1'b1;
            end
            PH_SIMPLE: begin
                if (i_mode == MODE_CLIQUE) begin
                    if (i_walk.y >= i_n) begin
                        o_walk.phase = PH_DONE;
                    end else if (i_walk.x >= i_n) begin
                        o_walk.y = y1[PW-1:0];
                        o_walk.x = '0;
                    end else if (i_walk.x == i_walk.y) begin
                        o_walk.x = x1[PW-1:0];
                    end else begin
                        o_emit   = 1'b1;
                        o_a      = i_walk.y;
                        o_b      = i_walk.x;
                        o_walk.x = x1[PW-1:0];
                    end
                end else if (y1 < {1'b0, i_n}) begin
                    o_emit   = 1'b1;
                    o_a      = i_walk.y;
                    o_b      = y1[PW-1:0];
                    o_walk.y = y1[PW-1:0];
                end else if (i_mode == MODE_RING && y1 == {1'b0, i_n}) begin
                    o_emit   = 1'b1;
                    o_a      = i_walk.y;
                    o_b      = '0;
                    o_walk.y = y1[PW-1:0];
                end else begin
                    o_walk.phase = PH_DONE;
                end
            end
            PH_ROWS: begin
                if (i_walk.y >= i_row_total || i_len < PW'(2)) begin
                    o_walk.phase = PH_COLS;
                    o_walk.x     = '0;
                    o_walk.y     = '0;
                    o_walk.off   = '0;
                    o_walk.cur   = i_len0;
                end else if (x1 < {1'b0, i_len}) begin
                    o_emit   = 1'b1;
                    o_a      = ox;
                    o_b      = ox + 1'b1;
                    o_walk.x = x1[PW-1:0];
                end else begin
                    o_emit     = 1'b1;
                    o_a        = ox;
                    o_b        = i_walk.off;
                    o_walk.off = i_walk.off + i_len;
                    o_walk.y   = y1[PW-1:0];
                    o_walk.x   = '0;
                end
            end
            PH_COLS: begin
                if (i_walk.x >= i_len0) begin
                    o_walk.phase = PH_DONE;
                end else if (y1 < {1'b0, i_row_total} && i_walk.x < i_len) begin
                    o_emit     = 1'b1;
                    o_a        = ox;
                    o_b        = ox + i_walk.cur;
                    o_walk.off = i_walk.off + i_walk.cur;
                    o_walk.y   = y1[PW-1:0];
                    o_walk.cur = i_len;
                end else if (i_walk.off == '0) begin
                    o_walk.phase = PH_DONE;
                end else begin
                    o_emit     = 1'b1;
                    o_a        = ox;
                    o_b        = i_walk.x;
                    o_walk.x   = x1[PW-1:0];
                    o_walk.y   = '0;
                    o_walk.off = '0;
                    o_walk.cur = i_len0;
                end
            end
            default: begin
                o_stop = 1'b1;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> sv/overlay_link_enumerator.sv
// Overlay link enumerator: one link (peer pair) of a line, ring, clique or torus per item.
// Walk step: a row store read, then an evaluate; each skipped clique diagonal or phase
//   change adds another step. One item in flight: a request is taken only in idle, once
//   the previous result has been taken. Restart: line/ring/clique add a count state;
//   torus adds the root search, sqrt(n)+1 row store writes and a counting walk of all links.
// Reset (sync, active low): idle, no links, count 0, peer_count 2, mode line; row store unreset.
`default_nettype none
module overlay_link_enumerator
    import olink_pkg::*;
#(
    parameter int MAX_PEERS = 1024,
    parameter int MAX_ROWS  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_restart,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_link_valid,
    output logic [9:0]       o_peer_a,
    output logic [9:0]       o_peer_b,
    output logic             o_last_link,
    output logic [19:0]      o_total_links
);
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [16:0] MP = 17'(MAX_PEERS);
    localparam logic [PW+1:0] MR = (PW+2)'(MAX_ROWS);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQRT = 7'b0000010,
        ST_REM  = 7'b0000100,
        ST_FILL = 7'b0001000,
        ST_CNTF = 7'b0010000,
        ST_RD   = 7'b0100000,
        ST_EV   = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_walk         r_walk, n_walk;
    logic [PW-1:0] r_cfg_n, r_n, r_len0, r_rtot, r_s, r_rem, r_i;
    logic [1:0]    r_cfg_mode, r_mode;
    logic [CW-1:0] r_cnt, r_sent;
    logic          r_counting, r_inr;
    logic          r_out_valid, r_lv, r_last;
    logic [9:0]    r_pa, r_pb;

    // Row store read: current row in the row walk, next row in the column walk.
    logic [PW:0]   rd_idx;
    logic [PW-1:0] rdata, len_eff;
    assign rd_idx  = (r_walk.phase == PH_ROWS) ? {1'b0, r_walk.y} : {1'b0, r_walk.y} + 1'b1;
    assign len_eff = r_inr ? rdata : '0;

    // Torus fill: rows below s hold s, the first ceil(rem/2) get one more; row s gets the rest.
    logic [PW-1:0] half_up, half_dn, fill_data;
    logic          fill_we;
    assign half_up   = PW'(({1'b0, r_rem} + 1'b1) >> 1);
    assign half_dn   = r_rem >> 1;
    assign fill_data = (r_i < r_s) ? r_s + PW'(r_i < half_up) : half_dn;
    assign fill_we   = (r_state == ST_FILL) && ({2'b0, r_i} < MR);

    olink_row_mem #(.DEPTH(MAX_ROWS), .AW(AW)) u_rows (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (r_i[AW-1:0]),
        .i_wdata (fill_data),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    t_walk         st_walk;
    logic          st_emit, st_stop;
    logic [PW-1:0] st_a, st_b;

    olink_step u_step (
        .i_walk      (r_walk),
        .i_len       (len_eff),
        .i_len0      (r_len0),
        .i_row_total (r_rtot),
        .i_n         (r_n),
        .i_mode      (r_mode),
        .o_walk      (st_walk),
        .o_emit      (st_emit),
        .o_stop      (st_stop),
        .o_a         (st_a),
        .o_b         (st_b)
    );

    logic          accept;
    logic [PW-1:0] n_cap, sp1;
    logic [2*PW-1:0] sq, ss, clq;
    logic [CW-1:0] sent_inc;
    assign o_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign accept   = i_valid && o_ready;
    assign n_cap    = ({6'b0, r_cfg_n} > MP) ? MP[PW-1:0] : r_cfg_n;
    assign sp1      = r_s + 1'b1;
    assign sq       = sp1 * sp1;
    assign ss       = r_s * r_s;
    assign clq      = r_n * (r_n - 1'b1);
    assign sent_inc = r_sent + 1'b1;
    assign n_walk   = st_walk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_walk.phase <= PH_DONE;
            r_cfg_n      <= PW'(2);
            r_cfg_mode   <= MODE_LINE;
            r_cnt        <= '0;
            r_sent       <= '0;
            r_out_valid  <= 1'b0;
            r_counting   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PEER_COUNT: r_cfg_n    <= i_cfg_data;
                    CFG_MODE:       r_cfg_mode <= i_cfg_data[1:0];
                    default:        r_cfg_mode <= r_cfg_mode;
                endcase
            end
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_restart) begin
                        r_n        <= n_cap;
                        r_mode     <= r_cfg_mode;
                        r_walk.x   <= '0;
                        r_walk.y   <= '0;
                        r_walk.off <= '0;
                        r_sent     <= '0;
                        r_cnt      <= '0;
                        r_counting <= 1'b0;
                        r_s        <= '0;
                        if (n_cap < PW'(2)) begin
                            r_walk.phase <= PH_DONE;
                        end else if (r_cfg_mode == MODE_TORUS) begin
                            r_walk.phase <= PH_ROWS;
                        end else begin
                            r_walk.phase <= PH_SIMPLE;
                        end
                    end
                end
                ST_SQRT: begin
                    if (sq <= {{PW{1'b0}}, r_n}) begin
                        r_s <= sp1;
                    end
                end
                ST_REM: begin
                    r_rem <= r_n - ss[PW-1:0];
                    r_i   <= '0;
                end
                ST_FILL: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == r_s) begin
                        // Row s counts only when it is stored and holds peers.
                        r_rtot     <= ({2'b0, r_s} < MR && half_dn != '0) ? sp1 : r_s;
                        r_len0     <= r_s + PW'(half_up != '0);
                        r_counting <= 1'b1;
                    end
                end
                ST_CNTF: begin
                    case (r_mode)
                        MODE_CLIQUE: r_cnt <= CW'(clq);
                        MODE_RING:   r_cnt <= CW'(r_n);
                        default:     r_cnt <= CW'(r_n - 1'b1);
                    endcase
                end
                ST_RD: begin
                    r_inr <= ({1'b0, rd_idx} < MR);
                end
                ST_EV: begin
                    if (r_counting) begin
                        if (st_stop) begin
                            // Count done: rewind the walk for the real first link.
                            r_walk.phase <= PH_ROWS;
                            r_walk.x     <= '0;
                            r_walk.y     <= '0;
                            r_walk.off   <= '0;
                            r_counting   <= 1'b0;
                        end else begin
                            r_walk <= n_walk;
                            if (st_emit) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                    end else begin
                        r_walk <= n_walk;
                        if (st_emit || st_stop) begin
                            r_out_valid <= 1'b1;
                            r_lv        <= st_emit;
                            r_pa        <= st_emit ? st_a[9:0] : 10'd0;
                            r_pb        <= st_emit ? st_b[9:0] : 10'd0;
                            r_last      <= st_emit && (sent_inc == r_cnt);
                            if (st_emit) begin
                                r_sent <= sent_inc;
                            end
                        end
                    end
                end
                default: begin
                    r_counting <= r_counting;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!i_restart || n_cap < PW'(2)) begin
                        n_state = ST_RD;
                    end else if (r_cfg_mode == MODE_TORUS) begin
                        n_state = ST_SQRT;
                    end else begin
                        n_state = ST_CNTF;
                    end
                end
            end
            ST_SQRT: begin
                if (sq > {{PW{1'b0}}, r_n}) begin
                    n_state = ST_REM;
                end
            end
            ST_REM:  n_state = ST_FILL;
            ST_FILL: begin
                if (r_i == r_s) begin
                    n_state = ST_RD;
                end
            end
            ST_CNTF: n_state = ST_RD;
            ST_RD:   n_state = ST_EV;
            ST_EV: begin
                if (!r_counting && (st_emit || st_stop)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_link_valid  = r_lv;
    assign o_peer_a      = r_pa;
    assign o_peer_b      = r_pb;
    assign o_last_link   = r_last;
    assign o_total_links = r_cnt[19:0];
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the overlay link enumerator.
`default_nettype none
module tb_top
    import olink_pkg::*;
;

    // One expected result item.
    typedef struct {
        bit       lv;
        bit [9:0] pa;
        bit [9:0] pb;
        bit       ll;
        bit [19:0] tot;
    } t_link;

    // One row of the directed table: a register write or a request item.
    typedef struct {
        bit        is_cfg;
        bit        idx;
        int        data;
        bit        rst;
        bit        typed;
        t_link     exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [10:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_restart = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b1;
    logic        o_link_valid;
    logic [9:0]  o_peer_a;
    logic [9:0]  o_peer_b;
    logic        o_last_link;
    logic [19:0] o_total_links;

    overlay_link_enumerator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_restart(i_restart),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_link_valid(o_link_valid), .o_peer_a(o_peer_a), .o_peer_b(o_peer_b),
        .o_last_link(o_last_link), .o_total_links(o_total_links)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: registers, latched walk and the row store.
    int     reg_peers = 2;
    int     reg_mode  = 0;
    int     row_len_q [64];
    int     rows_used;
    t_phase phase = PH_DONE;
    int     wx, wy, woff, wn, wmode;
    int     sent_cnt, link_total;

    t_link  pending_links [$];
    int     errors = 0;
    int     items_sent = 0;
    int     links_seen = 0;
    int     restarts = 0;
    bit     quiet = 1'b0;   // no idling on either side while set

    function automatic int row_len_at(int i);
        return (i >= 0 && i < 64) ? row_len_q[i] : 0;
    endfunction

    // Advance the walk by one link; return 0 when exhausted.
    function automatic bit step_walk(output int a, output int b);
        forever begin
            if (phase == PH_DONE) return 1'b0;
            if (phase == PH_SIMPLE) begin
                if (wmode == MODE_CLIQUE) begin
                    if (wy >= wn) begin phase = PH_DONE; continue; end
                    if (wx >= wn) begin wy++; wx = 0; continue; end
                    if (wx == wy) begin wx++; continue; end
                    a = wy; b = wx; wx++;
                    return 1'b1;
                end
                if (wy + 1 < wn) begin a = wy; b = wy + 1; wy++; return 1'b1; end
                if (wmode == MODE_RING && wy + 1 == wn) begin
                    a = wy; b = 0; wy++; return 1'b1;
                end
                phase = PH_DONE;
                continue;
            end
            if (phase == PH_ROWS) begin
                if (wy >= rows_used || row_len_at(wy) < 2) begin
                    phase = PH_COLS; wx = 0; wy = 0; woff = 0;
                    continue;
                end
                if (wx + 1 < row_len_at(wy)) begin
                    a = woff + wx; b = woff + wx + 1; wx++;
                end else begin
                    a = woff + wx; b = woff;
                    woff += row_len_at(wy); wy++; wx = 0;
                end
                return 1'b1;
            end
            // column walk
            if (wx >= row_len_at(0)) begin phase = PH_DONE; continue; end
            if (wy + 1 < rows_used && wx < row_len_at(wy + 1)) begin
                a = woff + wx; b = woff + row_len_at(wy) + wx;
                woff += row_len_at(wy); wy++;
                return 1'b1;
            end
            if (woff == 0) begin phase = PH_DONE; continue; end
            a = woff + wx; b = wx;
            wx++; wy = 0; woff = 0;
            return 1'b1;
        end
    endfunction

    // Lay out the torus rows: square core, leftovers to first rows and a last row.
    function automatic void arrange_torus(int n);
        int s, px, py, total;
        s = 0; px = 0; py = 0;
        while ((s + 1) * (s + 1) <= n) s++;
        total = s + 1;
        for (int i = 0; i < total; i++)
            if (i < 64) row_len_q[i] = (i < s) ? s : 0;
        for (int placed = s * s; placed < n; placed++) begin
            if (px < py) begin
                px++;
                if (s < 64) row_len_q[s] = px;
            end else begin
                if (py < 64) row_len_q[py] = row_len_at(py) + 1;
                py++;
            end
        end
        if (row_len_at(s) == 0) total--;
        rows_used = total;
    endfunction

    // Work out the result of one accepted request item.
    function automatic t_link next_link(bit rst);
        t_link r;
        int a, b, sx, sy, so, cnt;
        t_phase sp;
        bit ok;
        a = 0; b = 0;
        if (rst) begin
            wn = (reg_peers > 1024) ? 1024 : reg_peers;
            wmode = reg_mode;
            wx = 0; wy = 0; woff = 0;
            sent_cnt = 0; link_total = 0;
            if (wn < 2) phase = PH_DONE;
            else if (wmode == MODE_TORUS) begin
                arrange_torus(wn);
                phase = PH_ROWS;
            end else phase = PH_SIMPLE;
            if (wmode == MODE_CLIQUE && wn >= 2) link_total = wn * (wn - 1);
            else begin
                // dry run of the walk to count links, then restore
                sp = phase; sx = wx; sy = wy; so = woff; cnt = 0;
                while (step_walk(a, b)) cnt++;
                phase = sp; wx = sx; wy = sy; woff = so;
                link_total = cnt;
            end
        end
        ok = step_walk(a, b);
        if (ok) sent_cnt++;
        r.lv  = ok;
        r.pa  = ok ? a[9:0] : '0;
        r.pb  = ok ? b[9:0] : '0;
        r.ll  = ok && (sent_cnt == link_total);
        r.tot = link_total[19:0];
        return r;
    endfunction

    // Offer one request item; hold valid until accepted, then record the expectation.
    task automatic send_request(bit rst, bit typed, t_link typed_exp);
        int gap;
        t_link p;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= rst;
        do @(posedge i_clk); while (!o_ready);
        p = next_link(rst);
        pending_links.push_back(typed ? typed_exp : p);
        items_sent++;
        if (rst) restarts++;
    endtask

    // Write a register once the block has drained.
    task automatic write_reg(bit idx, int value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_links.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[10:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_PEER_COUNT) reg_peers = value & 'h7FF;
        else reg_mode = value & 3;
    endtask

    // Receive side: random stalls, compare each item with the oldest expectation.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_link e;
        int st;
        if (i_rst_n && o_valid && i_ready) begin
            links_seen++;
            if (pending_links.size() == 0) begin
                $display("%0t: unexpected item: link_valid %0d a %0d b %0d", $time,
                         o_link_valid, o_peer_a, o_peer_b);
                errors++;
            end else begin
                e = pending_links.pop_front();
                if (o_link_valid !== e.lv || o_peer_a !== e.pa || o_peer_b !== e.pb ||
                    o_last_link !== e.ll || o_total_links !== e.tot) begin
                    $display("%0t: mismatch exp lv %0d a %0d b %0d last %0d total %0d",
                             $time, e.lv, e.pa, e.pb, e.ll, e.tot);
                    $display("%0t:          got lv %0d a %0d b %0d last %0d total %0d",
                             $time, o_link_valid, o_peer_a, o_peer_b, o_last_link,
                             o_total_links);
                    errors++;
                end
            end
            st = quiet ? 0 : $urandom_range(0, 19);
            if (st > 0) begin
                i_ready    <= 1'b0;
                stall_left <= st;
            end
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_ready <= 1'b1;
        end
    end

    function automatic t_link mk(bit lv, int a, int b, bit ll, int tot);
        t_link r;
        r.lv = lv; r.pa = a[9:0]; r.pb = b[9:0]; r.ll = ll; r.tot = tot[19:0];
        return r;
    endfunction

    function automatic t_row cfg_row(bit idx, int v);
        t_row r;
        r.is_cfg = 1'b1; r.idx = idx; r.data = v; r.rst = 1'b0; r.typed = 1'b0;
        r.exp = mk(0, 0, 0, 0, 0);
        return r;
    endfunction

    function automatic t_row req_row(bit rst, bit typed, t_link e);
        t_row r;
        r.is_cfg = 1'b0; r.idx = 1'b0; r.data = 0; r.rst = rst; r.typed = typed;
        r.exp = e;
        return r;
    endfunction

    initial begin
        t_row  plan [$];
        t_link none;
        int    n, k, md;
        none = mk(0, 0, 0, 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset state, tiny counts, saturation, extremes.
        plan.push_back(req_row(0, 1, mk(0, 0, 0, 0, 0)));   // never started
        plan.push_back(req_row(1, 1, mk(1, 0, 1, 1, 1)));   // reset config: line of two
        plan.push_back(req_row(0, 1, mk(0, 0, 0, 0, 1)));   // exhausted
        plan.push_back(cfg_row(CFG_PEER_COUNT, 0));
        plan.push_back(req_row(1, 1, mk(0, 0, 0, 0, 0)));   // no peers
        plan.push_back(cfg_row(CFG_PEER_COUNT, 1));
        plan.push_back(req_row(1, 1, mk(0, 0, 0, 0, 0)));   // single peer
        plan.push_back(cfg_row(CFG_PEER_COUNT, 2));
        plan.push_back(cfg_row(CFG_MODE, MODE_RING));
        plan.push_back(req_row(1, 1, mk(1, 0, 1, 0, 2)));
        plan.push_back(req_row(0, 1, mk(1, 1, 0, 1, 2)));   // closing link
        plan.push_back(cfg_row(CFG_MODE, MODE_TORUS));
        plan.push_back(req_row(1, 1, mk(1, 0, 1, 0, 2)));   // two-peer torus
        plan.push_back(req_row(0, 1, mk(1, 1, 0, 1, 2)));
        plan.push_back(req_row(0, 1, mk(0, 0, 0, 0, 2)));
        plan.push_back(cfg_row(CFG_PEER_COUNT, 3));
        for (int i = 0; i < 4; i++) plan.push_back(req_row(i == 0, 0, none));
        plan.push_back(cfg_row(CFG_MODE, MODE_CLIQUE));
        for (int i = 0; i < 4; i++) plan.push_back(req_row(i == 0, 0, none));
        plan.push_back(cfg_row(CFG_PEER_COUNT, 2047));      // saturates to 1024
        plan.push_back(cfg_row(CFG_MODE, MODE_LINE));
        plan.push_back(req_row(1, 1, mk(1, 0, 1, 0, 1023)));
        plan.push_back(cfg_row(CFG_MODE, MODE_TORUS));      // ignored until restart
        plan.push_back(req_row(0, 1, mk(1, 1, 2, 0, 1023)));
        plan.push_back(cfg_row(CFG_MODE, MODE_CLIQUE));
        plan.push_back(req_row(1, 1, mk(1, 0, 1, 0, 1047552)));
        plan.push_back(cfg_row(CFG_MODE, MODE_TORUS));
        for (int i = 0; i < 3; i++) plan.push_back(req_row(i == 0, 0, none));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
            else send_request(plan[i].rst, plan[i].typed, plan[i].exp);
        end

        // Random part: per phase pick a topology, restart, then walk part of it.
        while (items_sent < 900) begin
            quiet = ($urandom_range(0, 4) == 0);
            k = $urandom_range(0, 19);
            if (k == 0) n = $urandom_range(1025, 2047);
            else if (k == 1) n = $urandom_range(0, 1);
            else if (k == 2) n = $urandom_range(41, 1024);
            else n = $urandom_range(2, 40);
            md = $urandom_range(0, 3);
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_PEER_COUNT, n);
                write_reg(CFG_MODE, md);
            end else begin
                write_reg(CFG_MODE, md);
                write_reg(CFG_PEER_COUNT, n);
            end
            send_request(1'b1, 1'b0, none);
            // walk a random number of items, up to the end and a little past it, capped at 60
            k = $urandom_range(0, (link_total + 2 > 60) ? 60 : link_total + 2);
            for (int i = 0; i < k; i++)
                send_request($urandom_range(0, 29) == 0, 1'b0, none);
        end
        i_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_links.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d request items (%0d restarts) over line, ring, clique and torus,",
                 items_sent, restarts);
        $display("received %0d items, %0d mismatches.", links_seen, errors);
        if (errors == 0 && pending_links.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        #40000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
